// File: src/i2a_pkg.sv
// Shared constants, state encoding and character mapping for the integer-to-text converter.
`default_nettype none

package i2a_pkg;

    // Default operand width and register layout.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DIGIT_W         = 6;
    localparam int CHAR_W          = 8;

    // Radix register: reset value and saturation limits.
    localparam logic [DIGIT_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [DIGIT_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [DIGIT_W-1:0] RADIX_DECIMAL = 6'd10;
    localparam logic [DIGIT_W-1:0] DIGIT_LIMIT   = 6'd36;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } i2a_state_t;

    // Map one digit value (0..35) to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d > 6'd9) begin
            ch = CHAR_A + CHAR_W'(d) - 8'd10;
        end else begin
            ch = CHAR_ZERO + CHAR_W'(d);
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: src/integer_to_ascii_radix.sv
// Top level of the integer-to-ASCII converter: divider, digit memory and character output.
`default_nettype none

// Converts one VALUE_WIDTH-bit integer per request into ASCII text in the radix held by the
// configuration register (2..36, reset 10; values outside are saturated). Characters leave most
// significant first, the final one with m_axis_tlast high; zero gives a single '0'. In radix ten a
// negative value is preceded by '-', in every other radix the value is taken as unsigned. Each
// digit comes from a shared restoring divider that retires 8 quotient bits per cycle. Digits are
// pushed into a small memory with a registered read. Once all digits are pushed, a sign state
// emits any minus sign, then each character is popped by a read state followed by an emit state.
// A new request is taken once the final character sits in the output register. Write the radix
// only while the block is idle.
module integer_to_ascii_radix
    import i2a_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // Configuration: radix register.
    input  wire logic                                   cfg_we,
    input  wire logic [DIGIT_W-1:0]                     cfg_wdata,
    // Input requests. tdata: value[VALUE_WIDTH-1:0], zero padding above.
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
    // Output characters. tdata: character[7:0]; tlast: last_char.
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [CHAR_W-1:0]                           m_axis_tdata,
    output logic                                        m_axis_tlast
);

    localparam int STEPS  = (VALUE_WIDTH + 7) / 8;
    localparam int DIV_W  = STEPS * 8;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int ADDR_W = $clog2(VALUE_WIDTH);

    // Registers.
    i2a_state_t          state_reg, state_next;
    logic [DIGIT_W-1:0]  radix_reg;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                neg_reg, neg_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    // Digit memory.
    logic [DIGIT_W-1:0]  stack_mem [VALUE_WIDTH];
    logic [DIGIT_W-1:0]  rd_data_reg;
    logic                mem_we;
    logic                rd_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    count_dec;

    // Datapath signals.
    logic [DIGIT_W-1:0]      radix_eff;
    logic [VALUE_WIDTH-1:0]  v_in;
    logic                    neg_in;
    logic [VALUE_WIDTH-1:0]  mag_in;
    logic [7:0]              q_byte;
    logic [DIGIT_W-1:0]      r_out;
    logic [DIV_W-1:0]        q_shift;
    logic                    last_step;
    logic                    out_free;

    // Saturate the configured radix to 2..36.
    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    // Sign handling: only radix ten shows a sign; the magnitude of the most negative value
    // fits the unsigned width exactly.
    assign v_in   = s_axis_tdata[VALUE_WIDTH-1:0];
    assign neg_in = (radix_eff == RADIX_DECIMAL) && v_in[VALUE_WIDTH-1];
    assign mag_in = neg_in ? ((~v_in) + VALUE_WIDTH'(1)) : v_in;

    // Eight restoring division steps on the top byte of the dividend shifter.
    always_comb begin
        logic [DIGIT_W:0]   t;
        logic [DIGIT_W-1:0] r;
        logic [7:0]         top;
        r   = rem_reg;
        top = div_reg[DIV_W-1 -: 8];
        for (int i = 7; i >= 0; i--) begin
            t = {r, top[i]};
            if (t >= {1'b0, radix_eff}) begin
                t         = t - {1'b0, radix_eff};
                q_byte[i] = 1'b1;
            end else begin
                q_byte[i] = 1'b0;
            end
            r = t[DIGIT_W-1:0];
        end
        r_out = r;
    end

    // Quotient bits enter from the bottom while dividend bits leave at the top.
    assign q_shift   = DIV_W'({div_reg, q_byte});
    assign last_step = (step_reg == STEP_W'(STEPS - 1));
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign count_dec = count_reg - CNT_W'(1);
    assign wr_addr   = count_reg[ADDR_W-1:0];
    assign rd_addr   = count_dec[ADDR_W-1:0];

    // Next state and datapath control.
    always_comb begin
        state_next   = state_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        s_axis_tready = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = aresetn;
                if (s_axis_tvalid) begin
                    neg_next   = neg_in;
                    div_next   = DIV_W'(mag_in);
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                // At least one digit is produced, which covers a zero input.
                div_next  = q_shift;
                rem_next  = r_out;
                step_next = step_reg + STEP_W'(1);
                if (last_step) begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    rem_next   = '0;
                    step_next  = '0;
                    if (q_shift == '0) begin
                        state_next = ST_SIGN;
                    end
                end
            end
            ST_SIGN: begin
                if (!neg_reg) begin
                    state_next = ST_READ;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = CHAR_MINUS;
                    m_last_next  = 1'b0;
                    neg_next     = 1'b0;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                count_next = count_dec;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = digit_to_char(rd_data_reg);
                    m_last_next  = (count_reg == '0);
                    state_next   = (count_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_RESET;
            count_reg   <= '0;
            step_reg    <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            neg_reg     <= neg_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                radix_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    // Digit memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= r_out;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // The digit count never exceeds the memory depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(VALUE_WIDTH))
        else $error("digit count beyond memory depth");

    // An accepted request starts a fresh division with an empty digit memory.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_DIVIDE && count_reg == '0))
        else $error("request did not start a division");

    // A pushed digit is always below the radix in use.
    a_digit_push: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (r_out < radix_eff))
        else $error("remainder not below radix");

    // A popped digit is always a valid digit value.
    a_digit_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rd_data_reg < DIGIT_LIMIT))
        else $error("popped digit out of range");

    // The input side is only ready while no conversion is in progress.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> (state_reg == ST_IDLE && !neg_reg))
        else $error("ready while busy");
`endif

endmodule

`default_nettype wire
